// File: hw/rtl/nkc_pkg.sv
`default_nettype none
package nkc_pkg;

  // fixed field and register widths
  localparam int PIX_W      = 16;
  localparam int COEF_W     = 16;
  localparam int OUT_W      = 16;
  localparam int IDX_W      = 6;
  localparam int RAD_W      = 2;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int LEVEL_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int ROW_CNT_W  = 12;
  localparam int MAX_HEIGHT = 4096;

  // defaults for the top level parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 3;
  localparam int DEF_PIXEL_BITS = 16;
  localparam int DEF_COEF_BITS  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS    = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2,
    REG_MAX_LEVEL = 2'd3
  } nkc_reg_t;

  typedef enum logic {
    ACT_COEF  = 1'b0,
    ACT_PIXEL = 1'b1
  } nkc_act_t;

  typedef struct packed {
    nkc_act_t                   action;
    logic [IDX_W-1:0]           coef_index;
    logic signed [COEF_W-1:0]   coef_value;
    logic [PIX_W-1:0]           pixel_value;
  } nkc_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] filtered_value;
    logic             row_end;
    logic             frame_end;
  } nkc_out_t;

  typedef struct packed {
    logic [RAD_W-1:0]    radius;
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [LEVEL_W-1:0]  max_level;
  } nkc_cfg_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } nkc_tag_t;

  function automatic int span_of(input int r);
    return 2 * r + 1;
  endfunction

  function automatic int taps_of(input int r);
    return (2 * r + 1) * (2 * r + 1);
  endfunction

  function automatic int wsum_w(input int cb, input int r);
    return cb + $clog2(taps_of(r));
  endfunction

  function automatic int acc_w(input int pb, input int cb, input int r);
    return pb + cb + 2 * $clog2(2 * r + 1);
  endfunction

  function automatic int mag_w(input int pb, input int cb, input int r);
    return (acc_w(pb, cb, r) > OUT_W) ? acc_w(pb, cb, r) : OUT_W + 1;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/nkc_ram.sv
`default_nettype none
module nkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/nkc_front.sv
`default_nettype none
module nkc_front #(
  parameter int MAX_WIDTH  = nkc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = nkc_pkg::DEF_MAX_RADIUS,
  parameter int PIXEL_BITS = nkc_pkg::DEF_PIXEL_BITS,
  parameter int COEF_BITS  = nkc_pkg::DEF_COEF_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  nkc_pkg::nkc_cfg_t cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  nkc_pkg::nkc_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [nkc_pkg::taps_of(MAX_RADIUS)-1:0][PIXEL_BITS-1:0] win_pix,
  output logic [nkc_pkg::taps_of(MAX_RADIUS)-1:0][COEF_BITS-1:0]  win_coef,
  output logic signed [nkc_pkg::wsum_w(COEF_BITS, MAX_RADIUS)-1:0] divisor,
  output nkc_pkg::nkc_tag_t out_tag
);
  import nkc_pkg::*;

  localparam int SPAN      = span_of(MAX_RADIUS);
  localparam int LINES     = 2 * MAX_RADIUS;
  localparam int TAPS      = taps_of(MAX_RADIUS);
  localparam int TAP_IDX_W = $clog2(TAPS);
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int WSUM_W    = wsum_w(COEF_BITS, MAX_RADIUS);
  localparam int LINE_W    = LINES * PIXEL_BITS;

  // effective configuration
  logic [RAD_W-1:0]    rad;
  logic [WW-1:0]       w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [RAD_W:0]      diam;

  always_comb begin
    if (cfg.radius == '0) begin
      rad = RAD_W'(1);
    end else if (int'(cfg.radius) > MAX_RADIUS) begin
      rad = RAD_W'(MAX_RADIUS);
    end else begin
      rad = cfg.radius;
    end
    if (cfg.width == '0) begin
      w_eff = WW'(1);
    end else if (int'(cfg.width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg.width);
    end
    if (cfg.height == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (int'(cfg.height) > MAX_HEIGHT) begin
      h_eff = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = cfg.height;
    end
  end

  assign diam = {rad, 1'b0};

  // raster position
  logic [COL_W-1:0]     col_cnt;
  logic [ROW_CNT_W-1:0] row_cnt;
  logic [WW-1:0]        col_inc;
  logic [HEIGHT_W-1:0]  row_inc;
  logic                 rend;
  logic                 fend;
  logic                 emit;
  logic                 accept;
  logic                 acc_pix;

  assign col_inc = WW'(col_cnt) + WW'(1);
  assign row_inc = HEIGHT_W'(row_cnt) + HEIGHT_W'(1);
  assign rend    = col_inc >= w_eff;
  assign fend    = rend && (row_inc >= h_eff);
  assign emit    = (ROW_CNT_W'(diam) <= row_cnt) && (COL_W'(diam) <= col_cnt);
  assign accept  = in_valid && in_ready;
  assign acc_pix = accept && (in_data.action == ACT_PIXEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (acc_pix) begin
      if (rend) begin
        col_cnt <= '0;
        row_cnt <= fend ? '0 : ROW_CNT_W'(row_inc);
      end else begin
        col_cnt <= COL_W'(col_inc);
      end
    end
  end

  // stage 1: line store read in flight
  logic                 v1;
  nkc_act_t             act1;
  logic [PIXEL_BITS-1:0] pix1;
  logic [COL_W-1:0]     col1;
  logic                 emit1;
  nkc_tag_t             tag1;
  logic [IDX_W-1:0]     cidx1;
  logic [COEF_BITS-1:0] cval1;
  logic                 fwd1;
  logic [LINE_W-1:0]    fwd_word1;

  // stage 2: window holds this item's neighborhood
  logic                 v2;
  nkc_act_t             act2;
  logic                 emit2;
  nkc_tag_t             tag2;
  logic [IDX_W-1:0]     cidx2;
  logic [COEF_BITS-1:0] cval2;

  logic ready1, ready2, leave1, leave2, cont2;

  assign cont2     = (act2 == ACT_PIXEL) && emit2;
  assign out_valid = v2 && cont2;
  assign leave2    = v2 && (!cont2 || out_ready);
  assign ready2    = !v2 || leave2;
  assign leave1    = v1 && ready2;
  assign ready1    = !v1 || ready2;
  assign in_ready  = ready1;

  // line store
  logic              ram_we;
  logic [LINE_W-1:0] ram_wdata;
  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] old_word;

  assign old_word  = fwd1 ? fwd_word1 : ram_rdata;
  assign ram_we    = leave1 && (act1 == ACT_PIXEL);
  assign ram_wdata = {pix1, old_word[LINE_W-1:PIXEL_BITS]};

  nkc_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(col1),
    .wdata(ram_wdata),
    .re   (acc_pix),
    .raddr(col_cnt),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act1          <= in_data.action;
      pix1          <= in_data.pixel_value[PIXEL_BITS-1:0];
      col1          <= col_cnt;
      emit1         <= emit;
      tag1.row_end  <= rend;
      tag1.frame_end <= fend;
      cidx1         <= in_data.coef_index;
      cval1         <= in_data.coef_value[COEF_BITS-1:0];
      // same column written back this cycle: the ram returns stale data
      fwd1          <= ram_we && (col1 == col_cnt);
      fwd_word1     <= ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (leave1) begin
      act2  <= act1;
      emit2 <= emit1;
      tag2  <= tag1;
      cidx2 <= cidx1;
      cval2 <= cval1;
    end
  end

  // window shift
  logic [PIXEL_BITS-1:0] win [SPAN][SPAN];

  always_ff @(posedge clk) begin
    if (ram_we) begin
      for (int y = 0; y < SPAN; y++) begin
        for (int x = 0; x + 1 < SPAN; x++) begin
          win[y][x] <= win[y][x+1];
        end
        win[y][SPAN-1] <= (y < LINES) ? old_word[y*PIXEL_BITS +: PIXEL_BITS] : pix1;
      end
    end
  end

  // coefficients and running weight
  logic signed [COEF_BITS-1:0] coefs [TAPS];
  logic signed [WSUM_W-1:0]    wsum;
  logic                        coef_wr;
  logic [TAP_IDX_W-1:0]        cslot;

  assign coef_wr = leave2 && (act2 == ACT_COEF) && (int'(cidx2) < TAPS);
  assign cslot   = cidx2[TAP_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      wsum <= '0;
      for (int i = 0; i < TAPS; i++) begin
        coefs[i] <= '0;
      end
    end else if (coef_wr) begin
      coefs[cslot] <= $signed(cval2);
      wsum <= wsum + WSUM_W'($signed(cval2)) - WSUM_W'(coefs[cslot]);
    end
  end

  assign divisor = (wsum == '0) ? WSUM_W'(1) : wsum;
  assign out_tag = tag2;

  // map the active kernel onto the lower right corner of the window
  for (genvar gy = 0; gy < SPAN; gy++) begin : g_row
    for (genvar gx = 0; gx < SPAN; gx++) begin : g_col
      logic [MAX_RADIUS-1:0][COEF_BITS-1:0] pick;
      logic [COEF_BITS-1:0]                 merged;

      for (genvar gr = 1; gr <= MAX_RADIUS; gr++) begin : g_rad
        localparam int N    = 2 * gr + 1;
        localparam int BASE = SPAN - N;
        if (gy >= BASE && gx >= BASE) begin : g_on
          assign pick[gr-1] = (rad == RAD_W'(gr)) ?
                              coefs[TAP_IDX_W'((gy - BASE) * N + (gx - BASE))] : '0;
        end else begin : g_off
          assign pick[gr-1] = '0;
        end
      end

      always_comb begin
        merged = '0;
        for (int k = 0; k < MAX_RADIUS; k++) begin
          merged = merged | pick[k];
        end
      end

      assign win_coef[gy*SPAN+gx] = merged;
      assign win_pix[gy*SPAN+gx]  = win[gy][gx];
    end
  end

  a_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("window stage dropped a waiting item");

  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    (acc_pix && rend) |=> (col_cnt == '0))
    else $error("column count not cleared at row end");

  a_row_wrap: assert property (@(posedge clk) disable iff (rst)
    (acc_pix && fend) |=> (row_cnt == '0))
    else $error("row count not cleared at frame end");

endmodule
`default_nettype wire

// File: hw/rtl/nkc_mac.sv
`default_nettype none
module nkc_mac #(
  parameter int MAX_RADIUS = nkc_pkg::DEF_MAX_RADIUS,
  parameter int PIXEL_BITS = nkc_pkg::DEF_PIXEL_BITS,
  parameter int COEF_BITS  = nkc_pkg::DEF_COEF_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [nkc_pkg::taps_of(MAX_RADIUS)-1:0][PIXEL_BITS-1:0] in_pix,
  input  logic [nkc_pkg::taps_of(MAX_RADIUS)-1:0][COEF_BITS-1:0]  in_coef,
  input  logic signed [nkc_pkg::wsum_w(COEF_BITS, MAX_RADIUS)-1:0] in_div,
  input  nkc_pkg::nkc_tag_t in_tag,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [nkc_pkg::acc_w(PIXEL_BITS, COEF_BITS, MAX_RADIUS)-1:0] out_acc,
  output logic signed [nkc_pkg::wsum_w(COEF_BITS, MAX_RADIUS)-1:0] out_div,
  output nkc_pkg::nkc_tag_t out_tag
);
  import nkc_pkg::*;

  localparam int SPAN   = span_of(MAX_RADIUS);
  localparam int TAPS   = taps_of(MAX_RADIUS);
  localparam int PROD_W = PIXEL_BITS + COEF_BITS;
  localparam int RSUM_W = PROD_W + $clog2(SPAN);
  localparam int ACC_W  = acc_w(PIXEL_BITS, COEF_BITS, MAX_RADIUS);
  localparam int WSUM_W = wsum_w(COEF_BITS, MAX_RADIUS);

  logic                     v_p, v_r, v_t;
  logic                     rdy_p, rdy_r, rdy_t;
  logic signed [PROD_W-1:0] prod [TAPS];
  logic signed [RSUM_W-1:0] rsum [SPAN];
  logic signed [RSUM_W-1:0] rsum_next [SPAN];
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [WSUM_W-1:0] div_p, div_r;
  nkc_tag_t                 tag_p, tag_r;

  assign rdy_t    = !v_t || out_ready;
  assign rdy_r    = !v_r || rdy_t;
  assign rdy_p    = !v_p || rdy_r;
  assign in_ready = rdy_p;
  assign out_valid = v_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p <= 1'b0;
      v_r <= 1'b0;
      v_t <= 1'b0;
    end else begin
      if (rdy_p) v_p <= in_valid;
      if (rdy_r) v_r <= v_p;
      if (rdy_t) v_t <= v_r;
    end
  end

  // one multiplier per tap
  always_ff @(posedge clk) begin
    if (rdy_p && in_valid) begin
      for (int i = 0; i < TAPS; i++) begin
        prod[i] <= PROD_W'($signed({1'b0, in_pix[i]})) * PROD_W'($signed(in_coef[i]));
      end
      div_p <= in_div;
      tag_p <= in_tag;
    end
  end

  always_comb begin
    for (int y = 0; y < SPAN; y++) begin
      rsum_next[y] = '0;
      for (int x = 0; x < SPAN; x++) begin
        rsum_next[y] = rsum_next[y] + RSUM_W'(prod[y*SPAN+x]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_r && v_p) begin
      rsum  <= rsum_next;
      div_r <= div_p;
      tag_r <= tag_p;
    end
  end

  always_comb begin
    acc_next = '0;
    for (int y = 0; y < SPAN; y++) begin
      acc_next = acc_next + ACC_W'(rsum[y]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_t && v_r) begin
      out_acc <= acc_next;
      out_div <= div_r;
      out_tag <= tag_r;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/nkc_div.sv
`default_nettype none
module nkc_div #(
  parameter int MAX_RADIUS = nkc_pkg::DEF_MAX_RADIUS,
  parameter int PIXEL_BITS = nkc_pkg::DEF_PIXEL_BITS,
  parameter int COEF_BITS  = nkc_pkg::DEF_COEF_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [nkc_pkg::acc_w(PIXEL_BITS, COEF_BITS, MAX_RADIUS)-1:0] in_acc,
  input  logic signed [nkc_pkg::wsum_w(COEF_BITS, MAX_RADIUS)-1:0] in_div,
  input  nkc_pkg::nkc_tag_t in_tag,
  input  logic [nkc_pkg::LEVEL_W-1:0] max_level,
  output logic out_valid,
  input  logic out_ready,
  output nkc_pkg::nkc_out_t out_data
);
  import nkc_pkg::*;

  localparam int ACC_W = acc_w(PIXEL_BITS, COEF_BITS, MAX_RADIUS);
  localparam int DIV_W = wsum_w(COEF_BITS, MAX_RADIUS);
  localparam int MAG_W = mag_w(PIXEL_BITS, COEF_BITS, MAX_RADIUS);
  localparam int HI_W  = MAG_W - OUT_W;
  localparam int CMP_W = (HI_W > DIV_W) ? HI_W : DIV_W;

  // magnitude stage
  logic               va, rdy_a;
  logic [MAG_W-1:0]   mag_a;
  logic [DIV_W-1:0]   dmag_a;
  logic               neg_a;
  nkc_tag_t           tag_a;
  logic signed [MAG_W-1:0] acc_ext;
  logic               acc_neg, div_neg;

  assign acc_ext = MAG_W'(in_acc);
  assign acc_neg = in_acc[ACC_W-1];
  assign div_neg = in_div[DIV_W-1];

  // quotient stages: index 0 holds the overflow check, then one bit each
  logic             v_st   [OUT_W+1];
  logic             rdy_st [OUT_W+1];
  logic [DIV_W-1:0] rem_st [OUT_W+1];
  logic [DIV_W-1:0] d_st   [OUT_W+1];
  logic [OUT_W-1:0] lo_st  [OUT_W+1];
  logic [OUT_W-1:0] q_st   [OUT_W+1];
  logic             sat_st [OUT_W+1];
  logic             neg_st [OUT_W+1];
  nkc_tag_t         tag_st [OUT_W+1];

  logic             vo, rdy_o;
  logic [CMP_W-1:0] hi_ext;

  assign rdy_o    = !vo || out_ready;
  assign rdy_a    = !va || rdy_st[0];
  assign in_ready = rdy_a;
  assign out_valid = vo;
  assign hi_ext   = CMP_W'(mag_a[MAG_W-1:OUT_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (rdy_a) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      mag_a  <= MAG_W'(acc_neg ? -acc_ext : acc_ext);
      dmag_a <= div_neg ? DIV_W'(-in_div) : DIV_W'(in_div);
      neg_a  <= acc_neg ^ div_neg;
      tag_a  <= in_tag;
    end
  end

  // a quotient of 2**OUT_W or more saturates, so only the low bits are developed
  always_ff @(posedge clk) begin
    if (rst) begin
      v_st[0] <= 1'b0;
    end else if (rdy_st[0]) begin
      v_st[0] <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_st[0] && va) begin
      sat_st[0] <= hi_ext >= CMP_W'(dmag_a);
      rem_st[0] <= DIV_W'(hi_ext);
      d_st[0]   <= dmag_a;
      lo_st[0]  <= mag_a[OUT_W-1:0];
      q_st[0]   <= '0;
      neg_st[0] <= neg_a;
      tag_st[0] <= tag_a;
    end
  end

  for (genvar k = 0; k < OUT_W; k++) begin : g_rdy
    assign rdy_st[k] = !v_st[k] || rdy_st[k+1];
  end
  assign rdy_st[OUT_W] = !v_st[OUT_W] || rdy_o;

  for (genvar k = 1; k <= OUT_W; k++) begin : g_step
    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           ge;

    assign trial = {rem_st[k-1], lo_st[k-1][OUT_W-1]};
    assign diff  = trial - {1'b0, d_st[k-1]};
    assign ge    = trial >= {1'b0, d_st[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_st[k] <= 1'b0;
      end else if (rdy_st[k]) begin
        v_st[k] <= v_st[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy_st[k] && v_st[k-1]) begin
        rem_st[k] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        d_st[k]   <= d_st[k-1];
        lo_st[k]  <= {lo_st[k-1][OUT_W-2:0], 1'b0};
        q_st[k]   <= {q_st[k-1][OUT_W-2:0], ge};
        sat_st[k] <= sat_st[k-1];
        neg_st[k] <= neg_st[k-1];
        tag_st[k] <= tag_st[k-1];
      end
    end
  end

  // clamp and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (rdy_o) begin
      vo <= v_st[OUT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && v_st[OUT_W]) begin
      if (neg_st[OUT_W]) begin
        out_data.filtered_value <= '0;
      end else if (sat_st[OUT_W] || (q_st[OUT_W] > OUT_W'(max_level))) begin
        out_data.filtered_value <= OUT_W'(max_level);
      end else begin
        out_data.filtered_value <= q_st[OUT_W];
      end
      out_data.row_end   <= tag_st[OUT_W].row_end;
      out_data.frame_end <= tag_st[OUT_W].frame_end;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/normalized_kernel_convolution.sv
`default_nettype none
// Normalized 2D convolution over a greyscale raster stream. Input transfers either load one
// kernel coefficient (action 0) or deliver one pixel in raster order (action 1); one transfer
// is taken every clock while the output side keeps up. A running sum of all stored
// coefficients is the divisor (1 when zero); each pixel that completes a full window gives one
// result, the quotient truncated toward zero and clamped to 0..max_level, tagged with row and
// frame end marks. Border pixels give no result. The pipeline runs through the line store and
// window, the multipliers and adder tree, and a divider with one stage per quotient bit. The
// line store is one ram read and written once per pixel, which sets the rate of one pixel per
// clock while the output is not stalled. Configure only while the block is idle.
module normalized_kernel_convolution #(
  parameter int MAX_WIDTH  = nkc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = nkc_pkg::DEF_MAX_RADIUS,
  parameter int PIXEL_BITS = nkc_pkg::DEF_PIXEL_BITS,
  parameter int COEF_BITS  = nkc_pkg::DEF_COEF_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  nkc_pkg::nkc_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output nkc_pkg::nkc_out_t                 out_data,
  input  logic                              cfg_write,
  input  logic [nkc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nkc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import nkc_pkg::*;

  localparam int TAPS   = taps_of(MAX_RADIUS);
  localparam int WSUM_W = wsum_w(COEF_BITS, MAX_RADIUS);
  localparam int ACC_W  = acc_w(PIXEL_BITS, COEF_BITS, MAX_RADIUS);

  // configuration registers
  nkc_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radius    <= RAD_W'(1);
      cfg.width     <= WIDTH_W'(1024);
      cfg.height    <= HEIGHT_W'(1024);
      cfg.max_level <= LEVEL_W'(255);
    end else if (cfg_write) begin
      case (nkc_reg_t'(cfg_index))
        REG_RADIUS:    cfg.radius    <= cfg_data[RAD_W-1:0];
        REG_WIDTH:     cfg.width     <= cfg_data[WIDTH_W-1:0];
        REG_HEIGHT:    cfg.height    <= cfg_data[HEIGHT_W-1:0];
        REG_MAX_LEVEL: cfg.max_level <= cfg_data[LEVEL_W-1:0];
        default:       cfg.radius    <= cfg.radius;
      endcase
    end
  end

  // front: counters, line store, window, coefficient store
  logic                                front_ready;
  logic                                win_valid, win_ready;
  logic [TAPS-1:0][PIXEL_BITS-1:0]     win_pix;
  logic [TAPS-1:0][COEF_BITS-1:0]      win_coef;
  logic signed [WSUM_W-1:0]            win_div;
  nkc_tag_t                            win_tag;

  nkc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS),
    .PIXEL_BITS(PIXEL_BITS),
    .COEF_BITS (COEF_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (front_ready),
    .in_data  (in_data),
    .out_valid(win_valid),
    .out_ready(win_ready),
    .win_pix  (win_pix),
    .win_coef (win_coef),
    .divisor  (win_div),
    .out_tag  (win_tag)
  );

  assign in_stall = !front_ready;

  // products and adder tree
  logic                     sum_valid, sum_ready;
  logic signed [ACC_W-1:0]  sum_acc;
  logic signed [WSUM_W-1:0] sum_div;
  nkc_tag_t                 sum_tag;

  nkc_mac #(
    .MAX_RADIUS(MAX_RADIUS),
    .PIXEL_BITS(PIXEL_BITS),
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .in_valid (win_valid),
    .in_ready (win_ready),
    .in_pix   (win_pix),
    .in_coef  (win_coef),
    .in_div   (win_div),
    .in_tag   (win_tag),
    .out_valid(sum_valid),
    .out_ready(sum_ready),
    .out_acc  (sum_acc),
    .out_div  (sum_div),
    .out_tag  (sum_tag)
  );

  // pipelined divide, clamp and output register
  nkc_div #(
    .MAX_RADIUS(MAX_RADIUS),
    .PIXEL_BITS(PIXEL_BITS),
    .COEF_BITS (COEF_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sum_valid),
    .in_ready (sum_ready),
    .in_acc   (sum_acc),
    .in_div   (sum_div),
    .in_tag   (sum_tag),
    .max_level(cfg.max_level),
    .out_valid(out_valid),
    .out_ready(!out_stall),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// File: sim/tb_normalized_kernel_convolution.sv
`timescale 1ns / 1ps
import nkc_pkg::*;

// expected-result store and convolution predictor
class conv_scoreboard;
  int unsigned   radius_reg, width_reg, height_reg, level_reg;
  logic [15:0]   line_mem [6][1024];
  logic [15:0]   win [7][7];
  int            coef_mem [49];
  int            weight_sum;
  int unsigned   col_cnt, row_cnt;
  nkc_out_t      pending_q [$];
  int            errors;

  function new();
    radius_reg = 1;
    width_reg  = 1024;
    height_reg = 1024;
    level_reg  = 255;
    foreach (line_mem[y, x]) line_mem[y][x] = '0;
    foreach (win[y, x]) win[y][x] = '0;
    foreach (coef_mem[i]) coef_mem[i] = 0;
    weight_sum = 0;
    col_cnt    = 0;
    row_cnt    = 0;
    errors     = 0;
  endfunction

  function void set_reg(nkc_reg_t idx, logic [15:0] val);
    case (idx)
      REG_RADIUS:    radius_reg = val & 16'h3;
      REG_WIDTH:     width_reg  = val & 16'h7FF;
      REG_HEIGHT:    height_reg = val & 16'h1FFF;
      REG_MAX_LEVEL: level_reg  = val;
      default: ;
    endcase
  endfunction

  // note one accepted input transfer and queue any result it causes
  function void note_input(nkc_in_t it);
    int unsigned r, n, w, h, col, row, b;
    longint acc, dv, q;
    bit rend, fend;
    nkc_out_t o;
    if (it.action == ACT_COEF) begin
      if (it.coef_index < 49) begin
        weight_sum += int'(it.coef_value) - coef_mem[it.coef_index];
        coef_mem[it.coef_index] = int'(it.coef_value);
      end
      return;
    end
    r = (radius_reg == 0) ? 1 : radius_reg;
    n = 2 * r + 1;
    w = (width_reg == 0) ? 1 : ((width_reg > 1024) ? 1024 : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > 4096) ? 4096 : height_reg);
    if (col_cnt >= 1024) col_cnt = 0;
    col = col_cnt;
    row = row_cnt;
    // window slides left, new column from the line rows plus the new pixel
    for (int y = 0; y < 7; y++) begin
      for (int x = 0; x < 6; x++) win[y][x] = win[y][x+1];
      win[y][6] = (y < 6) ? line_mem[y][col] : it.pixel_value;
    end
    for (int y = 0; y < 5; y++) line_mem[y][col] = line_mem[y+1][col];
    line_mem[5][col] = it.pixel_value;
    rend = (col + 1 >= w);
    fend = rend && (row + 1 >= h);
    if (rend) begin
      col_cnt = 0;
      row_cnt = fend ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
    end
    if (row < 2 * r || col < 2 * r) return;
    acc = 0;
    b = 7 - n;
    for (int y = 0; y < n; y++)
      for (int x = 0; x < n; x++)
        acc += longint'(win[b+y][b+x]) * longint'(coef_mem[y*n+x]);
    dv = (weight_sum == 0) ? 1 : longint'(weight_sum);
    q = acc / dv;
    if (q > longint'(level_reg)) q = level_reg;
    else if (q < 0) q = 0;
    o.filtered_value = q[15:0];
    o.row_end        = rend;
    o.frame_end      = fend;
    pending_q.push_back(o);
  endfunction

  function void check_result(nkc_out_t got);
    nkc_out_t exp_o;
    if (pending_q.size() == 0) begin
      $error("unexpected result %p", got);
      errors++;
      return;
    end
    exp_o = pending_q.pop_front();
    if (got.filtered_value !== exp_o.filtered_value) begin
      $error("filtered_value: expected %0d, got %0d", exp_o.filtered_value,
             got.filtered_value);
      errors++;
    end
    if (got.row_end !== exp_o.row_end) begin
      $error("row_end: expected %0d, got %0d", exp_o.row_end, got.row_end);
      errors++;
    end
    if (got.frame_end !== exp_o.frame_end) begin
      $error("frame_end: expected %0d, got %0d", exp_o.frame_end, got.frame_end);
      errors++;
    end
  endfunction
endclass

module tb_normalized_kernel_convolution;
  localparam int LATENCY_WAIT = 60;
  localparam longint CYCLE_LIMIT = 3000000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  nkc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  nkc_out_t out_data;
  logic     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  conv_scoreboard sb = new();
  longint cycles = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  int unsigned cur_w = 1024, cur_h = 1024;

  always #1 clk = ~clk;

  normalized_kernel_convolution dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_write, .cfg_index, .cfg_data
  );

  // result side: check every accepted transfer
  always @(posedge clk)
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);

  // receiver stalls in phases: none, random, sparse, periodic
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(1, 60);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 1);
      2: out_stall <= ($urandom_range(0, 7) == 0);
      default: out_stall <= (stall_left % 16 < 10);
    endcase
  end

  // run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // one input transfer, sender bursts with random gaps
  task automatic send_item(nkc_in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    burst_left--;
  endtask

  task automatic send_coef(int idx, logic [15:0] val);
    nkc_in_t it;
    it.action      = ACT_COEF;
    it.coef_index  = IDX_W'(idx);
    it.coef_value  = val;
    it.pixel_value = 16'($urandom);
    send_item(it);
  endtask

  task automatic send_pixel(logic [15:0] val);
    nkc_in_t it;
    it.action      = ACT_PIXEL;
    it.coef_index  = IDX_W'($urandom);
    it.coef_value  = 16'($urandom);
    it.pixel_value = val;
    send_item(it);
  endtask

  // hold the sender until every expected result is back, then let the pipe empty
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending_q.size() != 0);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  // registers change only with the pipe empty
  task automatic write_regs(int rad, int w, int h, int lvl);
    logic [15:0] vals [4];
    drain();
    vals = '{16'(rad), 16'(w), 16'(h), 16'(lvl)};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= nkc_reg_t'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(nkc_reg_t'(i), vals[i]);
    end
    cfg_write <= 1'b0;
    w = w & 11'h7FF;
    h = h & 13'h1FFF;
    cur_w = (w == 0) ? 1 : ((w > 1024) ? 1024 : w);
    cur_h = (h == 0) ? 1 : ((h > 4096) ? 4096 : h);
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return $urandom;
      default: return $urandom_range(0, 12) - 4;
    endcase
  endfunction

  // whole kernel reload, sometimes with stray out-of-range indexes
  task automatic load_kernel();
    for (int i = 0; i < 49; i++) send_coef(i, rand_coef());
    if ($urandom_range(0, 2) == 0) send_coef($urandom_range(49, 63), $urandom);
  endtask

  // one full frame; coefficient updates now and then inside it
  task automatic run_frame(bit pause_mid);
    int total;
    total = cur_w * cur_h;
    for (int i = 0; i < total; i++) begin
      if ($urandom_range(0, 39) == 0) send_coef($urandom_range(0, 63), rand_coef());
      if (pause_mid && i == total / 2) drain();
      send_pixel(rand_pixel());
    end
  endtask

  initial begin
    int done_items;
    int rv, wv, hv, lv;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // coefficient edge cases: extremes, overwrite, ignored indexes
    send_coef(0, 16'h7FFF);
    send_coef(48, 16'h8000);
    send_coef(0, 16'h0000);
    send_coef(49, 16'h1234);
    send_coef(63, 16'hFFFF);
    for (int i = 0; i < 9; i++) send_coef(i, 16'h0001);
    send_coef(4, 16'h0000);
    drain();

    // small 4x4 frame with a 3x3 kernel, pixel extremes and a mid-frame pause
    write_regs(1, 4, 4, 65535);
    run_frame(1'b1);
    drain();

    // zero registers fall back to one, then a single negative tap with clamp at zero level
    write_regs(0, 0, 0, 0);
    send_pixel(16'hFFFF);
    drain();
    for (int i = 0; i < 49; i++) send_coef(i, 16'h0000);
    send_coef(12, 16'hFFFF);
    write_regs(2, 6, 6, 0);
    run_frame(1'b0);
    drain();

    // register extremes: width past the line store saturates, then a 7x7 kernel over a 7x8 frame
    load_kernel();
    write_regs(1, 2047, 1, 255);
    run_frame(1'b0);
    drain();
    write_regs(3, 7, 8, 65535);
    run_frame(1'b0);
    drain();

    // random phases, small frames
    done_items = 0;
    while (done_items < 800) begin
      if ($urandom_range(0, 2) == 0) load_kernel();
      rv = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      if ($urandom_range(0, 39) == 0) begin
        wv = $urandom_range(0, 2047);
        hv = $urandom_range(0, 1);
      end else begin
        wv = $urandom_range(1, 16);
        hv = $urandom_range(0, 12);
      end
      lv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                       : $urandom_range(0, 255);
      write_regs(rv, wv, hv, lv);
      for (int f = $urandom_range(1, 3); f > 0; f--) begin
        run_frame(1'b0);
        done_items += cur_w * cur_h;
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
